/* rtl/word_length_histogram_assert.svh */
// Assertion macros for the word length histogram block.
`ifndef WORD_LENGTH_HISTOGRAM_ASSERT_SVH
`define WORD_LENGTH_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WLH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wlh assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WLH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wlh assertion failed");

`endif

/* rtl/wlh_pkg.sv */
// Shared constants, types and helpers of the word length histogram block.
`default_nettype none

package wlh_pkg;

  localparam int MAX_WORD_LEN = 20;
  localparam int COUNT_WIDTH  = 32;

  // Word length counter holds 0 up to MAX_WORD_LEN.
  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

  // Percentage in hundredths: quotient of (upper * 20000 + total) / (2 * total).
  localparam int PCT_W     = 14;
  localparam int SCALE_W   = 15;
  localparam int PCT_SCALE = 20000;
  localparam int PROD_W    = COUNT_WIDTH + SCALE_W;
  localparam int NUM_W     = COUNT_WIDTH + SCALE_W + 1;
  localparam int STEP_W    = $clog2(PCT_W);

  // Output field widths and tdata layout.
  localparam int BLEN_W  = 5;
  localparam int OCNT_W  = 32;
  localparam int OUT_DW  = BLEN_W + 3 * OCNT_W + PCT_W;
  localparam int OUT_TW  = ((OUT_DW + 7) / 8) * 8;

  // Whitespace and capital letter codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic byte_en;   // input transfer accepted this cycle
    logic mul;       // register upper * scale, rewind the bin scan
    logic div_load;  // set up the divider
    logic div_step;  // one quotient bit
    logic shift;     // advance the bin scan by one bin
    logic ld_bin;    // load bin 0 into the output register
    logic ld_sum;    // load the summary and clear the totals
  } wlh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bin0_nz;   // bin at the scan head is nonzero
    logic bin_last;  // scan head is the last bin
    logic out_free;  // output register can take an item this cycle
  } wlh_sts_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_cap(logic [7:0] c);
    return (c >= CH_A) && (c <= CH_Z);
  endfunction

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  // Show a count on a 32-bit field, all ones when it does not fit.
  function automatic logic [OCNT_W-1:0] clamp_out(cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF_FFFF) ? '1 : w[OCNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/word_length_histogram.sv */
// Word length histogram: top level joining controller and datapath.
//
// Usage: text bytes enter on the s_axis channel, one transfer per cycle
// while the block is collecting. s_axis_tlast marks the end of the text;
// that transfer's data byte is ignored and it closes any open word.
// After end of text the block stops accepting input, computes the
// uppercase percentage and reads out on m_axis: one transfer per nonzero
// length bin (shortest first), then one summary transfer with tuser and
// tlast high.
// Readout sequence: after the end-of-text transfer the block registers
// upper * scale, sets up the divider, runs the one-bit-per-cycle divider
// for all 14 quotient bits, then scans the bins one per cycle, holding on
// a nonzero bin until the output register is free.
// Reset clears all bins, totals and the open word. When the receiver
// holds m_axis_tready low the scan holds on the waiting bin; the output
// register keeps the pending transfer, and after the summary is loaded
// input resumes even while the summary still waits to be taken.
`default_nettype none
`include "word_length_histogram_assert.svh"

module word_length_histogram (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: text_byte [7:0]
  input  wire logic [7:0]                    s_axis_tdata,
  // tlast: end_of_text
  input  wire logic                          s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: bin_length [4:0], bin_count [36:5], words_seen [68:37],
  //        upper_words [100:69], upper_percent_hundredths [114:101], zero pad
  output logic [wlh_pkg::OUT_TW-1:0]         m_axis_tdata,
  // tuser: is_summary
  output logic                               m_axis_tuser,
  // tlast: last
  output logic                               m_axis_tlast
);

  wlh_pkg::wlh_cmd_t cmd;
  wlh_pkg::wlh_sts_t sts;

  // Controller: owns acceptance and readout sequencing.
  wlh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_eot_i   (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: counters, bins, divider and output register.
  wlh_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .text_byte_i   (s_axis_tdata),
    .eot_i         (s_axis_tlast),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_data_o    (m_axis_tdata),
    .out_summary_o (m_axis_tuser),
    .out_last_o    (m_axis_tlast)
  );

  // Input stays blocked the cycle after an end-of-text transfer.
  `WLH_ASSERT_NXT(a_eot_blocks_input, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
  // A pending bin result means a readout is in progress, so no input is taken.
  `WLH_ASSERT_IMP(a_bin_only_in_readout, m_axis_tvalid && !m_axis_tuser, !s_axis_tready)
  // Only the summary closes the run.
  `WLH_ASSERT_IMP(a_last_is_summary, m_axis_tvalid, m_axis_tlast == m_axis_tuser)
  // Percentage never exceeds 100.00.
  `WLH_ASSERT_IMP(a_pct_range, m_axis_tvalid && m_axis_tuser, m_axis_tdata[114:101] <= 14'd10000)

endmodule

`default_nettype wire

/* rtl/wlh_dpath.sv */
// Datapath: word tracking, length bins, totals, percentage divider, output register.
`default_nettype none

module wlh_dpath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire wlh_pkg::wlh_cmd_t          cmd_i,
  output wlh_pkg::wlh_sts_t               sts_o,
  input  wire logic [7:0]                 text_byte_i,
  input  wire logic                       eot_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic [wlh_pkg::OUT_TW-1:0]      out_data_o,
  output logic                            out_summary_o,
  output logic                            out_last_o
);

  localparam int MaxLen = wlh_pkg::MAX_WORD_LEN;
  localparam int LenW   = wlh_pkg::LEN_W;
  localparam int CntW   = wlh_pkg::COUNT_WIDTH;
  localparam int PctW   = wlh_pkg::PCT_W;
  localparam int ProdW  = wlh_pkg::PROD_W;
  localparam int NumW   = wlh_pkg::NUM_W;
  localparam int BlenW  = wlh_pkg::BLEN_W;
  localparam int OcntW  = wlh_pkg::OCNT_W;
  localparam int PadW   = wlh_pkg::OUT_TW - wlh_pkg::OUT_DW;

  logic [LenW-1:0]   len_q, len_d;
  logic              up_q, up_d;
  wlh_pkg::cnt_t     bins_q [MaxLen];
  wlh_pkg::cnt_t     total_q, uppc_q;
  logic [LenW-1:0]   sidx_q;
  logic [ProdW-1:0]  prod_q;
  logic [NumW-1:0]   rem_q, ds_q;
  logic [PctW-1:0]   quo_q;

  logic              close;
  logic [LenW-1:0]   clen;
  logic              cup;
  logic [LenW-1:0]   len_inc;
  logic              up_new;

  logic              ov_q;
  logic [BlenW-1:0]  o_blen_q;
  logic [OcntW-1:0]  o_cnt_q, o_tot_q, o_upp_q;
  logic [PctW-1:0]   o_pct_q;
  logic              o_sum_q;

  // Word tracking: decide whether this byte closes a word and with what length.
  always_comb begin
    len_inc = len_q + LenW'(1);
    up_new  = up_q & wlh_pkg::is_cap(text_byte_i);
    close   = 1'b0;
    clen    = len_q;
    cup     = up_q;
    len_d   = len_q;
    up_d    = up_q;
    if (cmd_i.byte_en) begin
      if (eot_i || wlh_pkg::is_blank(text_byte_i)) begin
        close = (len_q != '0);
        len_d = '0;
        up_d  = 1'b1;
      end else if (len_inc >= LenW'(MaxLen)) begin
        close = 1'b1;
        clen  = len_inc;
        cup   = up_new;
        len_d = '0;
        up_d  = 1'b1;
      end else begin
        len_d = len_inc;
        up_d  = up_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      up_q  <= 1'b1;
    end else begin
      len_q <= len_d;
      up_q  <= up_d;
    end
  end

  // Bins: saturating increment on close, shift toward bin 0 during the scan.
  for (genvar k = 0; k < MaxLen; k++) begin : g_bin
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        bins_q[k] <= '0;
      end else if (cmd_i.shift) begin
        if (k == MaxLen - 1) begin
          bins_q[k] <= '0;
        end else begin
          bins_q[k] <= bins_q[(k + 1) % MaxLen];
        end
      end else if (close && (clen == LenW'(k + 1))) begin
        bins_q[k] <= wlh_pkg::sat_inc(bins_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      uppc_q  <= '0;
    end else if (cmd_i.ld_sum) begin
      total_q <= '0;
      uppc_q  <= '0;
    end else if (close) begin
      total_q <= wlh_pkg::sat_inc(total_q);
      if (cup) begin
        uppc_q <= wlh_pkg::sat_inc(uppc_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sidx_q <= '0;
    end else if (cmd_i.mul) begin
      sidx_q <= '0;
    end else if (cmd_i.shift) begin
      sidx_q <= sidx_q + LenW'(1);
    end
  end

  // Percentage: multiply, then restoring division one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= ProdW'(uppc_q) * ProdW'(wlh_pkg::PCT_SCALE);
    end
    if (cmd_i.div_load) begin
      rem_q <= NumW'(prod_q) + NumW'(total_q);
      ds_q  <= NumW'({total_q, 1'b0}) << (PctW - 1);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= ds_q) begin
        rem_q <= rem_q - ds_q;
        quo_q <= {quo_q[PctW-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[PctW-2:0], 1'b0};
      end
      ds_q <= ds_q >> 1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.ld_bin || cmd_i.ld_sum) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_bin) begin
      o_blen_q <= BlenW'(sidx_q + LenW'(1));
      o_cnt_q  <= wlh_pkg::clamp_out(bins_q[0]);
      o_tot_q  <= '0;
      o_upp_q  <= '0;
      o_pct_q  <= '0;
      o_sum_q  <= 1'b0;
    end else if (cmd_i.ld_sum) begin
      o_blen_q <= '0;
      o_cnt_q  <= '0;
      o_tot_q  <= wlh_pkg::clamp_out(total_q);
      o_upp_q  <= wlh_pkg::clamp_out(uppc_q);
      o_pct_q  <= (total_q == '0) ? '0 : quo_q;
      o_sum_q  <= 1'b1;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_summary_o = o_sum_q;
  assign out_last_o    = o_sum_q;
  assign out_data_o    = {PadW'(0), o_pct_q, o_upp_q, o_tot_q, o_cnt_q, o_blen_q};

  assign sts_o.bin0_nz  = (bins_q[0] != '0);
  assign sts_o.bin_last = (sidx_q == LenW'(MaxLen - 1));
  assign sts_o.out_free = !ov_q || out_ready_i;

endmodule

`default_nettype wire

/* rtl/wlh_ctrl.sv */
// Controller: input acceptance, divider sequencing and readout of bins and summary.
`default_nettype none

module wlh_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_eot_i,
  output logic                   in_ready_o,
  input  wire wlh_pkg::wlh_sts_t sts_i,
  output wlh_pkg::wlh_cmd_t      cmd_o
);

  localparam int StepW = wlh_pkg::STEP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_SCAN,
    S_SUM
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.byte_en = in_valid_i;
        if (in_valid_i && in_eot_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.div_load = 1'b1;
        step_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + StepW'(1);
        if (step_q == StepW'(wlh_pkg::PCT_W - 1)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Skip empty bins, emit a nonzero one once the output register is free.
        if (!sts_i.bin0_nz) begin
          cmd_o.shift = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.ld_bin = 1'b1;
          cmd_o.shift  = 1'b1;
        end
        if (cmd_o.shift && sts_i.bin_last) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (sts_i.out_free) begin
          cmd_o.ld_sum = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire
